FILE: hdl/i2a_pkg.sv
// i2a_pkg: shared types, codes and character constants for the integer to ascii formatter
// used by i2a_ctrl, i2a_datapath and integer_to_ascii_formatter; depends on nothing

package i2a_pkg;

	// request operation codes; codes above OP_PTR carry no conversion
	typedef enum logic [2:0] {
		OP_SDEC = 3'd0,
		OP_UDEC = 3'd1,
		OP_LHEX = 3'd2,
		OP_UHEX = 3'd3,
		OP_PTR  = 3'd4
	} op_t;

	localparam int VALUE_W   = 64;
	localparam int HALF_W    = 32;
	localparam int DIGIT_W   = 4;
	localparam int NUM_DIGITS = 20;
	localparam int DIG_REG_W = NUM_DIGITS * DIGIT_W;
	localparam int CNT_W     = $clog2(NUM_DIGITS + 1);
	localparam int ITER_W    = $clog2(VALUE_W);
	localparam int CHAR_W    = 8;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;

	// which character the datapath puts out
	typedef enum logic [1:0] {
		EMIT_DIGIT = 2'd0,
		EMIT_MINUS = 2'd1,
		EMIT_ZERO  = 2'd2,
		EMIT_X     = 2'd3
	} emit_kind_t;

	typedef struct packed {
		logic       load;
		logic       conv_step;
		logic       skip_step;
		logic       emit;
		emit_kind_t emit_kind;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid_op;
		logic in_dec;
		logic in_ptr;
		logic in_neg;
		logic conv_last;
		logic top_zero;
		logic one_left;
	} dp_status_t;

endpackage

FILE: hdl/i2a_datapath.sv
// i2a_datapath: operand decode, bit-serial binary to bcd shifter, digit shift register
// and registered character output; depends on i2a_pkg

module i2a_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    operation,
	input  logic                          is_wide,
	input  logic [i2a_pkg::VALUE_W-1:0]   value,
	input  i2a_pkg::dp_cmd_t              cmd,
	output i2a_pkg::dp_status_t           status,
	output logic                          strobe,
	output logic [i2a_pkg::CHAR_W-1:0]    character,
	output logic                          last
);

	localparam int VW = i2a_pkg::VALUE_W;
	localparam int HW = i2a_pkg::HALF_W;
	localparam int DW = i2a_pkg::DIGIT_W;
	localparam int RW = i2a_pkg::DIG_REG_W;
	localparam int ND = i2a_pkg::NUM_DIGITS;

	logic [VW-1:0]                 bin_q;
	logic [RW-1:0]                 dig_q;
	logic [i2a_pkg::CNT_W-1:0]     cnt_q;
	logic [i2a_pkg::ITER_W-1:0]    iter_q;
	logic                          upper_q;
	logic                          strobe_q;
	logic [i2a_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;

	logic [VW-1:0]                 low_ext;
	logic [VW-1:0]                 sgn_ext;
	logic [VW-1:0]                 mag;
	logic                          neg;
	logic                          dec;
	logic                          ptr;
	logic                          valid_op;
	logic [RW-1:0]                 dig_adj;
	logic [DW-1:0]                 top_digit;
	logic [i2a_pkg::CHAR_W-1:0]    digit_char;

	// operand decode
	always_comb begin
		low_ext  = {{(VW-HW){1'b0}}, value[HW-1:0]};
		sgn_ext  = {{(VW-HW){value[HW-1]}}, value[HW-1:0]};
		neg      = 1'b0;
		dec      = 1'b0;
		ptr      = 1'b0;
		valid_op = 1'b1;
		mag      = is_wide ? value : low_ext;
		case (i2a_pkg::op_t'(operation))
			i2a_pkg::OP_SDEC: begin
				dec = 1'b1;
				neg = is_wide ? value[VW-1] : value[HW-1];
				if (neg) begin
					mag = is_wide ? (~value + 1'b1) : (~sgn_ext + 1'b1);
				end
			end
			i2a_pkg::OP_UDEC: begin
				dec = 1'b1;
			end
			i2a_pkg::OP_LHEX, i2a_pkg::OP_UHEX: begin
			end
			i2a_pkg::OP_PTR: begin
				ptr = 1'b1;
				mag = value;
			end
			default: begin
				valid_op = 1'b0;
			end
		endcase
	end

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			dig_adj[i*DW +: DW] = (dig_q[i*DW +: DW] >= 4'd5) ?
				dig_q[i*DW +: DW] + 4'd3 : dig_q[i*DW +: DW];
		end
	end

	assign top_digit = dig_q[RW-1 -: DW];

	always_comb begin
		if (top_digit < 4'd10) begin
			digit_char = i2a_pkg::CH_ZERO + {4'd0, top_digit};
		end else begin
			digit_char = (upper_q ? i2a_pkg::CH_UP_A : i2a_pkg::CH_LO_A) +
				{4'd0, top_digit - 4'd10};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			iter_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				cnt_q  <= i2a_pkg::CNT_W'(ND);
				iter_q <= '0;
			end else if (cmd.conv_step) begin
				iter_q <= iter_q + 1'b1;
			end else if (cmd.skip_step || (cmd.emit && cmd.emit_kind == i2a_pkg::EMIT_DIGIT)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upper_q <= (i2a_pkg::op_t'(operation) == i2a_pkg::OP_UHEX);
			if (dec) begin
				bin_q <= mag;
				dig_q <= '0;
			end else begin
				bin_q <= '0;
				dig_q <= {{(RW-VW){1'b0}}, mag};
			end
		end else if (cmd.conv_step) begin
			{dig_q, bin_q} <= {dig_adj[RW-2:0], bin_q, 1'b0};
		end else if (cmd.skip_step || (cmd.emit && cmd.emit_kind == i2a_pkg::EMIT_DIGIT)) begin
			dig_q <= {dig_q[RW-DW-1:0], {DW{1'b0}}};
		end
		if (cmd.emit) begin
			last_q <= cmd.emit_last;
			case (cmd.emit_kind)
				i2a_pkg::EMIT_DIGIT: char_q <= digit_char;
				i2a_pkg::EMIT_MINUS: char_q <= i2a_pkg::CH_MINUS;
				i2a_pkg::EMIT_ZERO:  char_q <= i2a_pkg::CH_ZERO;
				i2a_pkg::EMIT_X:     char_q <= i2a_pkg::CH_X;
				default:             char_q <= i2a_pkg::CH_ZERO;
			endcase
		end
	end

	assign status.in_valid_op = valid_op;
	assign status.in_dec      = dec;
	assign status.in_ptr      = ptr;
	assign status.in_neg      = neg;
	assign status.conv_last   = (iter_q == {i2a_pkg::ITER_W{1'b1}});
	assign status.top_zero    = (top_digit == '0);
	assign status.one_left    = (cnt_q == i2a_pkg::CNT_W'(1));

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

FILE: hdl/i2a_ctrl.sv
// i2a_ctrl: sequencing state machine for prefix, conversion, zero skip and digit emission
// depends on i2a_pkg; drives i2a_datapath through dp_cmd_t

module i2a_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  i2a_pkg::dp_status_t status,
	output i2a_pkg::dp_cmd_t    cmd,
	output logic                busy
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MINUS = 7'b0000010,
		ST_PRE0  = 7'b0000100,
		ST_PREX  = 7'b0001000,
		ST_CONV  = 7'b0010000,
		ST_SKIP  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!status.in_valid_op) begin
						state_d = ST_IDLE;
					end else if (status.in_ptr) begin
						state_d = ST_PRE0;
					end else if (status.in_neg) begin
						state_d = ST_MINUS;
					end else if (status.in_dec) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_SKIP;
					end
				end
			end
			ST_MINUS: begin
				cmd.emit      = 1'b1;
				cmd.emit_kind = i2a_pkg::EMIT_MINUS;
				state_d       = ST_CONV;
			end
			ST_PRE0: begin
				cmd.emit      = 1'b1;
				cmd.emit_kind = i2a_pkg::EMIT_ZERO;
				state_d       = ST_PREX;
			end
			ST_PREX: begin
				cmd.emit      = 1'b1;
				cmd.emit_kind = i2a_pkg::EMIT_X;
				state_d       = ST_SKIP;
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (status.top_zero && !status.one_left) begin
					cmd.skip_step = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.emit_kind = i2a_pkg::EMIT_DIGIT;
				cmd.emit_last = status.one_left;
				if (status.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_conv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && !status.conv_last) |=> state_q == ST_CONV)
		else $error("conversion left before all bits were shifted");
	a_skip_keeps_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip_step |-> !status.one_left)
		else $error("zero skip dropped the final digit");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> state_q == ST_IDLE)
		else $error("controller kept working after the last character");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("operand loaded while an item was in progress");
`endif

endmodule

FILE: hdl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, turns one integer per item into ascii characters
// depends on i2a_pkg, i2a_ctrl and i2a_datapath
//
//  channel   handshake          payload                           direction
//  request   start, busy        operation[2:0] is_wide value[63:0] in
//  result    strobe             character[7:0] last               out
//
// an item is taken at an edge with start high and busy low; busy then stays high
// until the last character has been issued (unused operation codes give no characters
// and leave busy low)
// decimal: a minus sign for a negative value, bit-serial binary to bcd shifting, then
// zero skip and digit output; hex and pointer skip the shifting, pointer puts 0x first
// characters come from a register, the cycle after they are formed; digits one per cycle
// arst_n clears the state machine, counters and strobe; the receiver cannot stall

module integer_to_ascii_formatter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   operation,
	input  logic                         is_wide,
	input  logic [i2a_pkg::VALUE_W-1:0]  value,
	output logic                         strobe,
	output logic [i2a_pkg::CHAR_W-1:0]   character,
	output logic                         last
);

	// commands from the sequencer, flags back from the datapath
	i2a_pkg::dp_cmd_t    cmd;
	i2a_pkg::dp_status_t status;

	i2a_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// operand decode, bcd shifter, digit register and character output
	i2a_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.operation (operation),
		.is_wide   (is_wide),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule
